@@ src/sonar_median_range_filter_defines.svh @@
// Assertion macros for the sonar median range filter checker.
// Expects aclk and aresetn in the scope where a macro is used.
`ifndef SONAR_MEDIAN_RANGE_FILTER_DEFINES_SVH
`define SONAR_MEDIAN_RANGE_FILTER_DEFINES_SVH

// Check outside of reset.
`define SMRF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that also covers the reset cycles.
`define SMRF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/smrf_pkg.sv @@
// Shared types and constants for the sonar median range filter.
// No dependencies.
package smrf_pkg;

    localparam int WINDOW_DEF  = 5;
    localparam int ECHO_W      = 16;
    localparam int DIST_W      = 24;
    localparam int SOUND_W     = 9;
    localparam int SOUND_SPEED = 343;
    localparam int PROD_W      = ECHO_W + SOUND_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL
    } state_t;

    typedef struct packed {
        logic              hit;
        logic [ECHO_W-1:0] candidate;
    } rank_status_t;

endpackage

@@ src/sonar_median_range_filter.sv @@
// Sonar median range filter: sliding-window median of echo times plus
// one-way distance in micrometres, floor(median * 343 / 2).
//
// Input channel s_*: one beat carries one echo time in microseconds. The
// beat is written over the oldest ring entry at acceptance; s_ready is high
// only while the sequencer is idle.
// Result channel m_*: one beat per input beat, the median echo time and
// the distance, held in an output register until m_ready takes it.
//
// Sequence: after acceptance the rank unit tests one ring entry per cycle
// against all others, stopping at the first entry that holds the middle
// rank; the product step (ST_MUL) then forms the distance product and
// loads it into the output register. A new beat is taken only after the
// previous one has left the product step and the sequencer is idle.
// While a result waits for m_ready the next beat is still accepted and
// scanned; it then holds in the product step until the output drains.
// Reset (aresetn low, synchronous) clears the ring to zeros, the write
// position, state and m_valid; unfilled entries take part in the median as zero.
module sonar_median_range_filter #(
    parameter int WINDOW = smrf_pkg::WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [smrf_pkg::ECHO_W-1:0]   s_echo_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [smrf_pkg::ECHO_W-1:0]   m_median_echo,
    output logic [smrf_pkg::DIST_W-1:0]   m_distance_um
);
    import smrf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [ECHO_W-1:0]             med_reg, med_next;
    logic                          m_valid_reg, m_valid_next;
    logic [ECHO_W-1:0]             m_med_reg, m_med_next;
    logic [DIST_W-1:0]             m_dist_reg, m_dist_next;
    logic                          wr_en;
    logic                          load_out;
    logic [PROD_W-1:0]             prod;
    logic [WINDOW-1:0][ECHO_W-1:0] entries;
    rank_status_t                  status;

    smrf_window #(.WINDOW(WINDOW)) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_data (s_echo_time),
        .entries (entries)
    );

    smrf_rank #(.WINDOW(WINDOW)) u_rank (
        .entries (entries),
        .idx     (idx_reg),
        .status  (status)
    );

    assign prod = PROD_W'(med_reg) * PROD_W'(SOUND_SPEED);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        med_next     = med_reg;
        load_out     = 1'b0;
        s_ready      = (state_reg == ST_IDLE);
        wr_en        = s_valid && (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (wr_en) begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.hit) begin
                    med_next   = status.candidate;
                    state_next = ST_MUL;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_MUL: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        m_valid_next = m_valid_reg;
        m_med_next   = m_med_reg;
        m_dist_next  = m_dist_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_med_next   = med_reg;
            m_dist_next  = prod[PROD_W-1 -: DIST_W];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        med_reg    <= med_next;
        m_med_reg  <= m_med_next;
        m_dist_reg <= m_dist_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_median_echo = m_med_reg;
    assign m_distance_um = m_dist_reg;

endmodule

@@ src/smrf_window.sv @@
// Ring of the most recent echo readings with its wrapping write position.
// Depends on smrf_pkg.
module smrf_window #(
    parameter int WINDOW = smrf_pkg::WINDOW_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wr_en,
    input  logic [smrf_pkg::ECHO_W-1:0]           wr_data,
    output logic [WINDOW-1:0][smrf_pkg::ECHO_W-1:0] entries
);
    import smrf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [WINDOW-1:0][ECHO_W-1:0] ring_reg;
    logic [IDX_W-1:0]              wr_pos_reg;
    logic [IDX_W-1:0]              wr_pos_next;

    always_comb begin
        wr_pos_next = wr_pos_reg;
        if (wr_en) begin
            if (wr_pos_reg == IDX_W'(WINDOW - 1)) begin
                wr_pos_next = '0;
            end else begin
                wr_pos_next = wr_pos_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg   <= '0;
            wr_pos_reg <= '0;
        end else begin
            wr_pos_reg <= wr_pos_next;
            if (wr_en) begin
                ring_reg[wr_pos_reg] <= wr_data;
            end
        end
    end

    assign entries = ring_reg;

endmodule

@@ src/smrf_rank.sv @@
// Rank test: compares one candidate entry against the whole window and
// flags it when it sits at the middle index of the sorted order. Depends on smrf_pkg.
module smrf_rank #(
    parameter int WINDOW = smrf_pkg::WINDOW_DEF
) (
    input  logic [WINDOW-1:0][smrf_pkg::ECHO_W-1:0] entries,
    input  logic [((WINDOW > 1) ? $clog2(WINDOW) : 1)-1:0] idx,
    output smrf_pkg::rank_status_t                  status
);
    import smrf_pkg::*;

    localparam int MID   = WINDOW / 2;
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [ECHO_W-1:0] cand;
    logic [CNT_W-1:0]  n_less;
    logic [CNT_W-1:0]  n_leq;

    assign cand = entries[idx];

    always_comb begin
        n_less = '0;
        n_leq  = '0;
        for (int i = 0; i < WINDOW; i++) begin
            n_less = n_less + CNT_W'(entries[i] < cand);
            n_leq  = n_leq + CNT_W'(entries[i] <= cand);
        end
    end

    // The candidate owns the middle slot when the slot falls inside its run of equals.
    assign status.hit       = (n_less <= CNT_W'(MID)) && (n_leq > CNT_W'(MID));
    assign status.candidate = cand;

endmodule

@@ src/smrf_checker.sv @@
// Port-level checker for the sonar median range filter, bound to the top level.
// Depends on smrf_pkg and sonar_median_range_filter_defines.svh.
`include "sonar_median_range_filter_defines.svh"

module smrf_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [smrf_pkg::ECHO_W-1:0]   s_echo_time,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [smrf_pkg::ECHO_W-1:0]   m_median_echo,
    input logic [smrf_pkg::DIST_W-1:0]   m_distance_um
);
    import smrf_pkg::*;

    logic [PROD_W-1:0] exp_prod;

    assign exp_prod = PROD_W'(m_median_echo) * PROD_W'(SOUND_SPEED);

    `SMRF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_median_echo), "result beat dropped or changed while stalled")
    `SMRF_ASSERT(a_dist_match, m_valid |-> (m_distance_um == exp_prod[PROD_W-1 -: DIST_W]), "distance does not match median")
    `SMRF_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "input taken again before scan")
    `SMRF_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid && s_ready, "reset did not clear the block")

endmodule

bind sonar_median_range_filter smrf_checker u_smrf_checker (.*);
